// ----- rtl/voxel_grid_point_accumulator_assert.svh -----
// Assertion macros for the voxel grid point accumulator checker.
`ifndef VOXEL_GRID_POINT_ACCUMULATOR_ASSERT_SVH
`define VOXEL_GRID_POINT_ACCUMULATOR_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define VGPA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define VGPA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ----- rtl/vgpa_pkg.sv -----
// Package with shared types and codes of the voxel grid point accumulator.
package vgpa_pkg;
    localparam int TABLE_ENTRIES = 4096;
    localparam int AXIS_BITS = 21;

    localparam logic [2:0] ST_EXISTING = 3'd0;
    localparam logic [2:0] ST_NEW      = 3'd1;
    localparam logic [2:0] ST_DROPPED  = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_READ_OK  = 3'd4;
    localparam logic [2:0] ST_EMPTY    = 3'd5;
    localparam logic [31:0] INV_LEAF_RESET = 32'd1310720;
    localparam int PROD_FRAC = 26;

    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [31:0] divisor;
        logic        is_signed;
    } div_req_t;
endpackage

// ----- rtl/vgpa_ram.sv -----
// Generic single-port RAM with registered read.
module vgpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// ----- rtl/vgpa_div.sv -----
// Radix-2 restoring divider for a 64-bit dividend by a 32-bit divisor.
module vgpa_div (
    input  logic                 clk,
    input  logic                 rst_n,
    input  vgpa_pkg::div_req_t   req,
    output logic                 done,
    output logic [63:0]          quotient
);
    import vgpa_pkg::*;

    logic [63:0] quo_reg, quo_next;
    logic [32:0] rem_reg, rem_next;
    logic [31:0] den_reg, den_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        neg_reg, neg_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [32:0] trial;
    logic [63:0] mag;

    assign mag = (req.is_signed && req.dividend[63]) ? (64'd0 - req.dividend) : req.dividend;
    assign trial = {rem_reg[31:0], quo_reg[63]} - {1'b0, den_reg};

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            quo_next  = mag;
            rem_next  = 33'd0;
            den_next  = req.divisor;
            cnt_next  = 7'd0;
            neg_next  = req.is_signed && req.dividend[63];
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial[32])
            begin
                rem_next = {rem_reg[31:0], quo_reg[63]};
                quo_next = {quo_reg[62:0], 1'b0};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[62:0], 1'b1};
            end
            cnt_next = cnt_reg + 7'd1;
            if (cnt_reg == 7'd63)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 7'd0;
            neg_reg  <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            neg_reg  <= neg_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quotient = neg_reg ? (64'd0 - quo_reg) : quo_reg;
endmodule

// ----- rtl/voxel_grid_point_accumulator.sv -----
// Top level of the voxel grid point accumulator.
//  channel  | handshake              | payload
//  command  | start, busy            | kind, pos_x/y/z, intensity, inten_valid, finite, read_slot
//  result   | done                   | status, slot, voxel_points, voxel_total, voxel_id, means
//  config   | cfg_valid, cfg_ready   | cfg_data (inv_leaf_q16)
// An add forms the key one axis at a time on one shared multiplier, then compares each
// occupied slot through the key RAM, then updates a matching entry or writes a new one and
// updates it, or reports full. A read of a filled slot fetches the entry, then runs four
// divisions on the shared divider. A dropped point answers from idle, an empty read as soon
// as its slot is found unused. Reset clears the control state only; no clearing pass is needed.
// The receiver cannot stall; each result shows on done for one cycle.
module voxel_grid_point_accumulator (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       kind,
    input  logic signed [31:0]         pos_x,
    input  logic signed [31:0]         pos_y,
    input  logic signed [31:0]         pos_z,
    input  logic [15:0]                intensity,
    input  logic                       inten_valid,
    input  logic                       finite,
    input  logic [11:0]                read_slot,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [31:0]                cfg_data,
    output logic                       done,
    output logic [2:0]                 status,
    output logic [11:0]                slot,
    output logic [31:0]                voxel_points,
    output logic [12:0]                voxel_total,
    output logic [62:0]                voxel_id,
    output logic signed [31:0]         mean_x,
    output logic signed [31:0]         mean_y,
    output logic signed [31:0]         mean_z,
    output logic [15:0]                mean_intensity
);
    import vgpa_pkg::*;

    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam int CW = AW + 1;
    localparam int KW = 3 * AXIS_BITS;
    localparam int DW = 64 * 3 + 48 + 32;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_KEY  = 4'd1;
    localparam logic [3:0] S_SCAN = 4'd2;
    localparam logic [3:0] S_CMP  = 4'd3;
    localparam logic [3:0] S_RD   = 4'd4;
    localparam logic [3:0] S_UPD  = 4'd5;
    localparam logic [3:0] S_RRD  = 4'd6;
    localparam logic [3:0] S_RWT  = 4'd7;
    localparam logic [3:0] S_DIV  = 4'd8;

    logic [3:0]  state_reg, state_next;
    logic [31:0] inv_reg;
    logic [CW-1:0] occ_reg, occ_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [1:0]  ax_reg, ax_next;
    logic [1:0]  dq_reg, dq_next;
    logic        new_reg, new_next;
    logic signed [31:0] px_reg, py_reg, pz_reg;
    logic [15:0] in_reg;
    logic [11:0] rslot_reg;
    logic [KW-1:0] key_reg, key_next;
    logic signed [63:0] prod_reg;
    logic        prod_v_reg;

    logic        done_reg, done_next;
    logic [2:0]  st_reg, st_next;
    logic [11:0] slot_reg, slot_next;
    logic [31:0] cnt_reg, cnt_next;
    logic [62:0] id_reg, id_next;
    logic [31:0] mx_reg, my_reg, mz_reg;
    logic [15:0] mi_reg;

    logic          key_we, dat_we;
    logic [AW-1:0] ram_addr;
    logic [KW-1:0] key_rd;
    logic [DW-1:0] dat_wd, dat_rd;
    div_req_t      dreq;
    logic          ddone;
    logic [63:0]   dquo;

    logic [1:0]  mul_sel;
    logic signed [31:0] mul_a;
    logic [AXIS_BITS-1:0] ax_idx;
    logic signed [63:0] fl;
    logic signed [63:0] sx, sy, sz;
    logic [47:0] si;
    logic [31:0] np;

    assign sx = dat_rd[DW-1 -: 64];
    assign sy = dat_rd[DW-65 -: 64];
    assign sz = dat_rd[DW-129 -: 64];
    assign si = dat_rd[79:32];
    assign np = dat_rd[31:0];

    vgpa_ram #(.WIDTH(KW), .DEPTH(TABLE_ENTRIES)) u_key (
        .clk(clk), .we(key_we), .addr(ram_addr), .wdata(key_reg), .rdata(key_rd));
    vgpa_ram #(.WIDTH(DW), .DEPTH(TABLE_ENTRIES)) u_dat (
        .clk(clk), .we(dat_we), .addr(ram_addr), .wdata(dat_wd), .rdata(dat_rd));
    vgpa_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .done(ddone), .quotient(dquo));

    // The multiplier runs one axis ahead of the key assembly once its first product is out.
    assign mul_sel = ax_reg + {1'b0, prod_v_reg};

    always_comb
    begin
        unique case (mul_sel)
            2'd0:    mul_a = px_reg;
            2'd1:    mul_a = py_reg;
            default: mul_a = pz_reg;
        endcase
    end

    assign fl = prod_reg >>> PROD_FRAC;
    assign ax_idx = fl[AXIS_BITS-1:0] + {1'b1, {(AXIS_BITS-1){1'b0}}};

    always_ff @(posedge clk)
    begin
        prod_reg <= 64'(mul_a) * $signed({32'd0, inv_reg});
    end

    always_comb
    begin
        dreq.start = 1'b0;
        dreq.is_signed = 1'b1;
        dreq.divisor = np;
        unique case (dq_reg)
            2'd0:    dreq.dividend = sx;
            2'd1:    dreq.dividend = sy;
            2'd2:    dreq.dividend = sz;
            default: begin dreq.dividend = {16'd0, si}; dreq.is_signed = 1'b0; end
        endcase
        if ((state_reg == S_RWT && np != 32'd0) || (state_reg == S_DIV && ddone && dq_reg != 2'd3))
        begin
            dreq.start = 1'b1;
            if (state_reg == S_DIV)
            begin
                unique case (dq_reg)
                    2'd0:    dreq.dividend = sy;
                    2'd1:    dreq.dividend = sz;
                    default: begin dreq.dividend = {16'd0, si}; dreq.is_signed = 1'b0; end
                endcase
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        occ_next = occ_reg;
        idx_next = idx_reg;
        ax_next = ax_reg;
        dq_next = dq_reg;
        new_next = new_reg;
        key_next = key_reg;
        done_next = 1'b0;
        st_next = st_reg;
        slot_next = slot_reg;
        cnt_next = cnt_reg;
        id_next = id_reg;
        key_we = 1'b0;
        dat_we = 1'b0;
        ram_addr = idx_reg[AW-1:0];
        dat_wd = dat_rd;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    st_next = ST_DROPPED;
                    slot_next = 12'd0;
                    cnt_next = 32'd0;
                    id_next = 63'd0;
                    ax_next = 2'd0;
                    idx_next = '0;
                    dq_next = 2'd0;
                    if (kind)
                    begin
                        state_next = S_RRD;
                    end
                    else if (!finite)
                    begin
                        done_next = 1'b1;
                    end
                    else
                    begin
                        state_next = S_KEY;
                    end
                end
            end
            S_KEY:
            begin
                if (ax_reg != 2'd0 || prod_v_reg)
                begin
                    key_next = {ax_idx, key_reg[KW-1:AXIS_BITS]};
                    ax_next = ax_reg + 2'd1;
                    if (ax_reg == 2'd2)
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (idx_reg >= occ_reg)
                begin
                    if (occ_reg >= CW'(TABLE_ENTRIES))
                    begin
                        st_next = ST_FULL;
                        id_next = 63'(key_reg);
                        done_next = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        new_next = 1'b1;
                        key_we = 1'b1;
                        dat_we = 1'b1;
                        dat_wd = '0;
                        occ_next = occ_reg + CW'(1);
                        state_next = S_RD;
                    end
                end
                else
                begin
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                if (key_rd == key_reg)
                begin
                    new_next = 1'b0;
                    state_next = S_UPD;
                end
                else
                begin
                    idx_next = idx_reg + CW'(1);
                    state_next = S_SCAN;
                end
            end
            S_RD:
            begin
                state_next = S_UPD;
            end
            S_UPD:
            begin
                dat_we = 1'b1;
                if (np != 32'hFFFF_FFFF)
                begin
                    dat_wd = {sx + 64'(px_reg), sy + 64'(py_reg), sz + 64'(pz_reg),
                              si + 48'(in_reg), np + 32'd1};
                    cnt_next = np + 32'd1;
                end
                else
                begin
                    cnt_next = np;
                end
                st_next = new_reg ? ST_NEW : ST_EXISTING;
                slot_next = 12'(idx_reg);
                id_next = 63'(key_reg);
                done_next = 1'b1;
                state_next = S_IDLE;
            end
            S_RRD:
            begin
                ram_addr = AW'(rslot_reg);
                if (CW'(rslot_reg) < occ_reg)
                begin
                    state_next = S_RWT;
                end
                else
                begin
                    st_next = ST_EMPTY;
                    slot_next = rslot_reg;
                    done_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_RWT:
            begin
                ram_addr = AW'(rslot_reg);
                st_next = ST_READ_OK;
                slot_next = rslot_reg;
                cnt_next = np;
                id_next = 63'(key_rd);
                if (np == 32'd0)
                begin
                    done_next = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                ram_addr = AW'(rslot_reg);
                if (ddone)
                begin
                    dq_next = dq_reg + 2'd1;
                    if (dq_reg == 2'd3)
                    begin
                        done_next = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            inv_reg <= INV_LEAF_RESET;
            occ_reg <= '0;
            done_reg <= 1'b0;
            prod_v_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            occ_reg <= occ_next;
            done_reg <= done_next;
            prod_v_reg <= (state_reg == S_KEY);
            if (cfg_valid && cfg_ready)
            begin
                inv_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        ax_reg <= ax_next;
        dq_reg <= dq_next;
        new_reg <= new_next;
        key_reg <= key_next;
        st_reg <= st_next;
        slot_reg <= slot_next;
        cnt_reg <= cnt_next;
        id_reg <= id_next;
        if (state_reg == S_IDLE && start)
        begin
            px_reg <= pos_x;
            py_reg <= pos_y;
            pz_reg <= pos_z;
            in_reg <= inten_valid ? intensity : 16'd0;
            rslot_reg <= read_slot;
            mx_reg <= 32'd0;
            my_reg <= 32'd0;
            mz_reg <= 32'd0;
            mi_reg <= 16'd0;
        end
        else if (state_reg == S_DIV && ddone)
        begin
            unique case (dq_reg)
                2'd0:    mx_reg <= dquo[31:0];
                2'd1:    my_reg <= dquo[31:0];
                2'd2:    mz_reg <= dquo[31:0];
                default: mi_reg <= dquo[15:0];
            endcase
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE) && !start;
    assign done = done_reg;
    assign status = st_reg;
    assign slot = slot_reg;
    assign voxel_points = cnt_reg;
    assign voxel_total = 13'(occ_reg);
    assign voxel_id = id_reg;
    assign mean_x = mx_reg;
    assign mean_y = my_reg;
    assign mean_z = mz_reg;
    assign mean_intensity = mi_reg;
endmodule

// ----- rtl/vgpa_checker.sv -----
// Port-level checker for the voxel grid point accumulator, with its bind.
module vgpa_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic [2:0]  status,
    input logic [12:0] voxel_total,
    input logic        cfg_ready
);
    `include "voxel_grid_point_accumulator_assert.svh"

    `VGPA_ASSERT_IMP(a_status_code, clk, rst_n, done, status <= 3'd5)
    `VGPA_ASSERT_NEXT(a_busy_after_start, clk, rst_n, start && !busy, busy || done)
    `VGPA_ASSERT_IMP(a_total_monotonic, clk, rst_n, 1'b1, voxel_total >= $past(voxel_total))
    `VGPA_ASSERT_IMP(a_no_cfg_busy, clk, rst_n, busy, !cfg_ready)
endmodule

bind voxel_grid_point_accumulator vgpa_checker u_vgpa_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done),
    .status(status), .voxel_total(voxel_total), .cfg_ready(cfg_ready));

// ----- bench/voxel_grid_point_accumulator_tb.sv -----
// Self-checking testbench for the voxel grid point accumulator: directed table, then random traffic.
`timescale 1ns / 1ps

module voxel_grid_point_accumulator_tb;
    import vgpa_pkg::*;

    localparam logic KIND_ADD = 1'b0;
    localparam logic KIND_READ = 1'b1;
    localparam int ENTRIES = 4096;
    localparam longint CYCLE_LIMIT = 10000000;

    typedef struct {
        logic               kind;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic [15:0]        inten;
        logic               has;
        logic               fin;
        logic [11:0]        rslot;
    } point_cmd_t;

    typedef struct {
        logic [2:0]         status;
        logic [11:0]        slot;
        logic [31:0]        count;
        logic [12:0]        total;
        logic [62:0]        id;
        logic signed [31:0] mx;
        logic signed [31:0] my;
        logic signed [31:0] mz;
        logic [15:0]        mi;
    } voxel_result_t;

    typedef struct {
        point_cmd_t    cmd;
        bit            typed;
        voxel_result_t res;
    } directed_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic kind = 1'b0;
    logic signed [31:0] pos_x = '0;
    logic signed [31:0] pos_y = '0;
    logic signed [31:0] pos_z = '0;
    logic [15:0] intensity = '0;
    logic inten_valid = 1'b0;
    logic finite = 1'b0;
    logic [11:0] read_slot = '0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [31:0] cfg_data = '0;
    logic done;
    logic [2:0] status;
    logic [11:0] slot;
    logic [31:0] voxel_points;
    logic [12:0] voxel_total;
    logic [62:0] voxel_id;
    logic signed [31:0] mean_x;
    logic signed [31:0] mean_y;
    logic signed [31:0] mean_z;
    logic [15:0] mean_intensity;

    voxel_grid_point_accumulator u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .kind(kind),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z), .intensity(intensity),
        .inten_valid(inten_valid), .finite(finite), .read_slot(read_slot),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .done(done), .status(status), .slot(slot), .voxel_points(voxel_points),
        .voxel_total(voxel_total), .voxel_id(voxel_id), .mean_x(mean_x),
        .mean_y(mean_y), .mean_z(mean_z), .mean_intensity(mean_intensity)
    );

    // Shadow copy of the voxel table.
    logic [31:0]   leaf_q16 = INV_LEAF_RESET;
    logic [62:0]   vox_key [ENTRIES];
    longint        vox_sum_x [ENTRIES];
    longint        vox_sum_y [ENTRIES];
    longint        vox_sum_z [ENTRIES];
    longint        vox_sum_i [ENTRIES];
    logic [31:0]   vox_points [ENTRIES];
    int            slot_of_key [logic [62:0]];
    int            vox_used = 0;

    voxel_result_t pending_results[$];
    directed_row_t directed_rows[$];
    point_cmd_t    point_pool[$];
    int            error_count = 0;
    longint        cycle_count = 0;
    bit            allow_idle = 1'b1;

    initial
    begin
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("voxel_grid_point_accumulator_tb: done, errors");
            $finish;
        end
    end

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch on %s: got %h, expected %h (cycle %0d)", what, got, want, cycle_count);
        error_count++;
    endtask

    function automatic logic [20:0] axis_index(input logic signed [31:0] pos);
        longint prod;
        longint q;
        prod = longint'(pos) * longint'({32'b0, leaf_q16});
        q = prod >>> PROD_FRAC;
        return q[20:0] + 21'h100000;
    endfunction

    function automatic voxel_result_t accumulate_point(input point_cmd_t c);
        voxel_result_t r;
        logic [62:0] k;
        int hit;
        r = '{default: '0};
        if (c.kind == KIND_READ)
        begin
            r.slot = c.rslot;
            if (int'(c.rslot) < vox_used)
            begin
                r.status = ST_READ_OK;
                r.count = vox_points[c.rslot];
                r.id = vox_key[c.rslot];
                if (r.count != 0)
                begin
                    r.mx = 32'(vox_sum_x[c.rslot] / longint'({32'b0, r.count}));
                    r.my = 32'(vox_sum_y[c.rslot] / longint'({32'b0, r.count}));
                    r.mz = 32'(vox_sum_z[c.rslot] / longint'({32'b0, r.count}));
                    r.mi = 16'(vox_sum_i[c.rslot] / longint'({32'b0, r.count}));
                end
            end
            else
            begin
                r.status = ST_EMPTY;
            end
        end
        else if (!c.fin)
        begin
            r.status = ST_DROPPED;
        end
        else
        begin
            k = {axis_index(c.z), axis_index(c.y), axis_index(c.x)};
            r.id = k;
            hit = -1;
            if (slot_of_key.exists(k))
            begin
                hit = slot_of_key[k];
                r.status = ST_EXISTING;
            end
            else if (vox_used >= ENTRIES)
            begin
                r.status = ST_FULL;
            end
            else
            begin
                hit = vox_used;
                vox_used++;
                slot_of_key[k] = hit;
                vox_key[hit] = k;
                vox_sum_x[hit] = 0;
                vox_sum_y[hit] = 0;
                vox_sum_z[hit] = 0;
                vox_sum_i[hit] = 0;
                vox_points[hit] = 0;
                r.status = ST_NEW;
            end
            if (hit >= 0)
            begin
                if (vox_points[hit] != 32'hFFFF_FFFF)
                begin
                    vox_sum_x[hit] += longint'(c.x);
                    vox_sum_y[hit] += longint'(c.y);
                    vox_sum_z[hit] += longint'(c.z);
                    vox_sum_i[hit] += c.has ? longint'(c.inten) : 0;
                    vox_points[hit]++;
                end
                r.slot = 12'(hit);
                r.count = vox_points[hit];
            end
        end
        r.total = 13'(vox_used);
        return r;
    endfunction

    always @(posedge clk)
    begin
        voxel_result_t e;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                report("unexpected result", 64'(done), 64'd0);
            end
            else
            begin
                e = pending_results.pop_front();
                if (status !== e.status) report("status", 64'(status), 64'(e.status));
                if (slot !== e.slot) report("slot", 64'(slot), 64'(e.slot));
                if (voxel_points !== e.count)
                    report("voxel_points", 64'(voxel_points), 64'(e.count));
                if (voxel_total !== e.total)
                    report("voxel_total", 64'(voxel_total), 64'(e.total));
                if (voxel_id !== e.id) report("voxel_id", 64'(voxel_id), 64'(e.id));
                if (mean_x !== e.mx) report("mean_x", 64'(mean_x), 64'(e.mx));
                if (mean_y !== e.my) report("mean_y", 64'(mean_y), 64'(e.my));
                if (mean_z !== e.mz) report("mean_z", 64'(mean_z), 64'(e.mz));
                if (mean_intensity !== e.mi)
                    report("mean_intensity", 64'(mean_intensity), 64'(e.mi));
            end
        end
    end

    task automatic send_point(input point_cmd_t c, input bit typed, input voxel_result_t want);
        voxel_result_t r;
        int gap;
        start <= 1'b1;
        kind <= c.kind;
        pos_x <= c.x;
        pos_y <= c.y;
        pos_z <= c.z;
        intensity <= c.inten;
        inten_valid <= c.has;
        finite <= c.fin;
        read_slot <= c.rslot;
        do @(posedge clk); while (busy);
        r = accumulate_point(c);
        pending_results.push_back(typed ? want : r);
        if (allow_idle && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 10);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0 || busy) @(posedge clk);
    endtask

    task automatic write_leaf(input logic [31:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        leaf_q16 = v;
        @(posedge clk);
    endtask

    function automatic point_cmd_t make_cmd(input logic k, input logic [31:0] x, input logic [31:0] y,
                                            input logic [31:0] z, input logic [15:0] i,
                                            input logic h, input logic f, input logic [11:0] s);
        point_cmd_t c;
        c.kind = k;
        c.x = x;
        c.y = y;
        c.z = z;
        c.inten = i;
        c.has = h;
        c.fin = f;
        c.rslot = s;
        return c;
    endfunction

    function automatic void add_row(input point_cmd_t c, input bit typed, input voxel_result_t r);
        directed_row_t row;
        row.cmd = c;
        row.typed = typed;
        row.res = r;
        directed_rows.push_back(row);
    endfunction

    function automatic point_cmd_t random_cmd();
        point_cmd_t c;
        int pick;
        pick = $urandom_range(0, 99);
        c = make_cmd(KIND_ADD, $urandom, $urandom, $urandom, 16'($urandom), 1'($urandom), 1'b1,
                     12'($urandom));
        if (pick < 55 && point_pool.size() != 0)
        begin
            c = point_pool[$urandom_range(0, point_pool.size() - 1)];
            c.inten = 16'($urandom);
            c.has = 1'($urandom);
        end
        else if (pick < 70)
        begin
            c.x = $signed($urandom_range(0, 8191)) - 4096;
            c.y = $signed($urandom_range(0, 8191)) - 4096;
            c.z = $signed($urandom_range(0, 8191)) - 4096;
        end
        else if (pick < 88)
        begin
            c.kind = KIND_READ;
            if ($urandom_range(0, 3) != 0 && vox_used != 0)
                c.rslot = 12'($urandom_range(0, vox_used - 1));
        end
        else if (pick < 95)
        begin
            c.fin = 1'b0;
        end
        return c;
    endfunction

    initial
    begin
        voxel_result_t none;
        voxel_result_t first;
        logic [31:0] leaf_steps [5];
        point_cmd_t c;
        none = '{default: '0};
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        first = none;
        first.status = ST_EMPTY;
        add_row(make_cmd(KIND_READ, 32'd0, 32'd0, 32'd0, 16'd0, 1'b0, 1'b0, 12'd0), 1'b1, first);
        first.status = ST_DROPPED;
        add_row(make_cmd(KIND_ADD, 32'h7FFF_FFFF, 32'd0, 32'd0, 16'hFFFF, 1'b1, 1'b0, 12'd0),
                1'b1, first);
        first.status = ST_NEW;
        first.count = 32'd1;
        first.total = 13'd1;
        first.id = {21'h100000, 21'h100000, 21'h100000};
        add_row(make_cmd(KIND_ADD, 32'd0, 32'd0, 32'd0, 16'd0, 1'b0, 1'b1, 12'd0), 1'b1, first);
        add_row(make_cmd(KIND_ADD, 32'd1, 32'd2, 32'd3, 16'hFFFF, 1'b1, 1'b1, 12'd0), 1'b0, none);
        add_row(make_cmd(KIND_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 16'hFFFF,
                         1'b1, 1'b1, 12'd0), 1'b0, none);
        add_row(make_cmd(KIND_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 16'h1234,
                         1'b0, 1'b1, 12'd0), 1'b0, none);
        add_row(make_cmd(KIND_ADD, 32'hFFFF_FFFF, 32'hFFFF_FC00, 32'hFFFF_FFCC, 16'h0001,
                         1'b1, 1'b1, 12'd0), 1'b0, none);
        add_row(make_cmd(KIND_ADD, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 16'd0,
                         1'b1, 1'b1, 12'd0), 1'b0, none);
        add_row(make_cmd(KIND_READ, 32'd0, 32'd0, 32'd0, 16'd0, 1'b0, 1'b0, 12'd0), 1'b0, none);
        add_row(make_cmd(KIND_READ, 32'd0, 32'd0, 32'd0, 16'd0, 1'b0, 1'b0, 12'd1), 1'b0, none);
        add_row(make_cmd(KIND_READ, 32'd0, 32'd0, 32'd0, 16'd0, 1'b0, 1'b0, 12'd2), 1'b0, none);
        add_row(make_cmd(KIND_READ, 32'd0, 32'd0, 32'd0, 16'd0, 1'b0, 1'b0, 12'd3), 1'b0, none);
        first = none;
        first.status = ST_EMPTY;
        first.slot = 12'hFFF;
        first.total = 13'd4;
        add_row(make_cmd(KIND_READ, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF,
                         1'b1, 1'b1, 12'hFFF), 1'b1, first);
        foreach (directed_rows[i])
            send_point(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].res);

        leaf_steps[0] = 32'd0;
        leaf_steps[1] = 32'd1;
        leaf_steps[2] = 32'hFFFF_FFFF;
        leaf_steps[3] = $urandom;
        leaf_steps[4] = INV_LEAF_RESET;
        for (int p = 0; p < 5; p++)
        begin
            write_leaf(leaf_steps[p]);
            point_pool.delete();
            for (int j = 0; j < 24; j++)
                point_pool.push_back(make_cmd(KIND_ADD, $urandom, $urandom, $urandom, 16'd0,
                                              1'b0, 1'b1, 12'd0));
            for (int j = 0; j < 340; j++)
            begin
                allow_idle = (j % 100) < 70 && !(p == 4 && j >= 240);
                c = random_cmd();
                send_point(c, 1'b0, none);
            end
        end
        start <= 1'b0;

        while (pending_results.size() != 0) @(posedge clk);
        repeat (400) @(posedge clk);
        if (error_count == 0)
            $display("voxel_grid_point_accumulator_tb: done, clean");
        else
            $display("voxel_grid_point_accumulator_tb: done, errors");
        $finish;
    end
endmodule

// ----- sim.f -----
+incdir+rtl
rtl/vgpa_pkg.sv
rtl/vgpa_ram.sv
rtl/vgpa_div.sv
rtl/voxel_grid_point_accumulator.sv
rtl/vgpa_checker.sv
bench/voxel_grid_point_accumulator_tb.sv
